### rtl/pfxc_pkg.sv
// Shared types and constants for the plaintext feedback cipher.
package pfxc_pkg;

   localparam logic [1:0] FUNC_KEY = 2'd0;
   localparam logic [1:0] FUNC_ENC = 2'd1;
   localparam logic [1:0] FUNC_DEC = 2'd2;

   localparam logic [31:0] KEY_MUL = 32'hE377_9B97;
   localparam logic [63:0] KEY_ADD = 64'h0000_0000_9E37_79B9;
   localparam logic [7:0] BYTE_MASK = 8'hff;

   localparam int HIST_DEPTH = 256;
   localparam int HIST_AW = 8;
   localparam int POS_W = 9;

   typedef struct packed {
      logic key_load;
      logic data_load;
      logic div_step;
      logic mask_capture;
      logic mul_lo;
      logic mul_hi;
   } cmd_type;

   typedef struct packed {
      logic key_item;
      logic data_item;
      logic pos_zero;
      logic last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### rtl/pfxc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfxc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pfxc_ctrl.sv
// Controller state machine sequencing the cipher datapath.
module pfxc_ctrl
   import pfxc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CAPT  = 3'd3;
   localparam logic [2:0] ST_MULLO = 3'd4;
   localparam logic [2:0] ST_MULHI = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE) && status.out_free;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.key_item) begin
               cmd.key_load = 1'b1;
            end
            if (accept && status.data_item) begin
               cmd.data_load = 1'b1;
               if (status.last) begin
                  state_in = ST_MULLO;
               end else if (!status.pos_zero) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            cmd.mask_capture = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_MULHI;
         end
         ST_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/pfxc_dpath.sv
// Datapath: key, mask, position, remainder unit, history RAM and result register.
module pfxc_dpath
   import pfxc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,
   input  logic [2:0] req_tuser,
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   input  cmd_type    cmd,
   output status_type status
);

   logic [63:0]      key_ff, key_in;
   logic [2:0]       slot_ff, slot_eff;
   logic [7:0]       mask_ff, mask_eff;
   logic [POS_W-1:0] pos_ff, pos_eff;
   logic [POS_W-1:0] divisor_ff;
   logic [7:0]       dvd_ff;
   logic [7:0]       rem_ff;
   logic [2:0]       cnt_ff;
   logic [63:0]      acc_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;

   logic [1:0]       func;
   logic             first;
   logic [7:0]       result;
   logic [7:0]       plain;
   logic [63:0]      key_base;
   logic [63:0]      key_addend;
   logic [POS_W-1:0] trial;
   logic [63:0]      lo_prod;
   logic [31:0]      hi_prod;
   logic             hist_we;
   logic [7:0]       hist_rd_data;

   assign func  = req_tuser[1:0];
   assign first = req_tuser[2];

   assign slot_eff   = first ? 3'd0 : slot_ff;
   assign key_base   = first ? 64'd0 : key_ff;
   assign key_addend = {56'd0, req_tdata} << {slot_eff, 3'b000};

   assign mask_eff = first ? (key_ff[7:0] & BYTE_MASK) : mask_ff;
   assign pos_eff  = first ? '0 : pos_ff;
   assign result   = req_tdata ^ mask_eff;
   assign plain    = (func == FUNC_ENC) ? req_tdata : result;
   assign hist_we  = cmd.data_load && !pos_eff[POS_W-1];

   assign trial   = {rem_ff, dvd_ff[7]};
   assign lo_prod = {32'd0, key_ff[31:0]} * {32'd0, KEY_MUL};
   assign hi_prod = key_ff[63:32] * KEY_MUL;
   assign key_in  = acc_ff + {hi_prod, 32'd0} + KEY_ADD;

   assign status.key_item  = (func == FUNC_KEY);
   assign status.data_item = (func == FUNC_ENC) || (func == FUNC_DEC);
   assign status.pos_zero  = (pos_eff == '0);
   assign status.last      = req_tlast;
   assign status.div_done  = (cnt_ff == 3'd7);
   assign status.out_free  = !out_valid_ff || rsp_tready;

   pfxc_ram #(
      .WIDTH(8),
      .DEPTH(HIST_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (hist_we),
      .wr_addr(pos_eff[HIST_AW-1:0]),
      .wr_data(plain),
      .rd_addr(rem_ff),
      .rd_data(hist_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         slot_ff      <= '0;
         mask_ff      <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.key_load) begin
            key_ff  <= key_base + key_addend;
            slot_ff <= slot_eff + 3'd1;
         end
         if (cmd.data_load) begin
            mask_ff <= mask_eff;
            pos_ff  <= pos_eff + {{(POS_W-1){1'b0}}, !pos_eff[POS_W-1]};
            cnt_ff  <= '0;
         end
         if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         if (cmd.mask_capture) begin
            mask_ff <= hist_rd_data;
         end
         if (cmd.mul_hi) begin
            key_ff  <= key_in;
            mask_ff <= key_in[7:0] & BYTE_MASK;
            pos_ff  <= '0;
         end
         if (cmd.data_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.data_load) begin
         divisor_ff  <= pos_eff;
         dvd_ff      <= mask_eff;
         rem_ff      <= '0;
         out_byte_ff <= result;
         out_last_ff <= req_tlast;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[6:0], 1'b0};
         if (trial >= divisor_ff) begin
            rem_ff <= 8'(trial - divisor_ff);
         end else begin
            rem_ff <= trial[7:0];
         end
      end
      if (cmd.mul_lo) begin
         acc_ff <= lo_prod;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/plaintext_feedback_xor_cipher_top.sv
// Top level of the plaintext feedback packet byte cipher.
//
//   channel   direction  tdata          tuser             tlast
//   req_      in         data_byte      func, first       last
//   rsp_      out        out_byte       -                 end_of_packet
//
// A key byte, and a data byte at packet position 0 that is not last, end at accept.
// Other non-last data bytes go through accept, 8 steps of the bit-serial
// remainder unit (mask mod position), history RAM read, mask capture.
// A last data byte: accept, then two 32-bit multiply steps of the key update.
// Reset is synchronous; key, mask and position clear, history holds no valid data.
// A request waits while busy or while the result register is full and not taken.
module plaintext_feedback_xor_cipher_top
   import pfxc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [2:0] req_tuser,   // [1:0] func, [2] first
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   pfxc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   pfxc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### tb/sv/plaintext_feedback_xor_cipher_top_tb.sv
// Self-checking testbench for the plaintext feedback packet byte cipher.
module plaintext_feedback_xor_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfxc_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 700;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       has_exp;
      logic [7:0] exp_byte;
      logic       exp_eop;
   } cipher_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       eop;
   } cipher_rsp_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOP} rx_mode_type;

   localparam cipher_req_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{FUNC_ENC,  8'hA5, 1'b1, 1'b0, 1'b1, 8'hA5, 1'b0},
      '{FUNC_ENC,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENC,  8'hFF, 1'b0, 1'b1, 1'b1, 8'h5A, 1'b1},
      '{FUNC_DEC,  8'h00, 1'b0, 1'b1, 1'b1, 8'hB9, 1'b1},
      '{FUNC_KEY,  8'h3C, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
      '{FUNC_ENC,  8'hFF, 1'b1, 1'b1, 1'b1, 8'hC3, 1'b1},
      '{FUNC_KEY,  8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_ENC,  8'h5A, 1'b1, 1'b1, 1'b1, 8'h5A, 1'b1},
      '{FUNC_NONE, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
      '{FUNC_DEC,  8'h81, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_KEY,  8'h12, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_DEC,  8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{FUNC_ENC,  8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic [2:0] req_tuser = 3'd0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   cipher_req_type request_queue[$];
   cipher_rsp_type expected_bytes[$];
   cipher_req_type driven_req = '0;
   bit          req_taken = 1'b0;
   int          planned_count = 0;
   int          accepted_count = 0;
   int          live_count = 0;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          rx_left = 0;
   int          rx_phase = 0;
   rx_mode_type rx_mode = RX_OPEN;

   logic [63:0] key_acc = '0;
   logic [2:0]  key_slot = '0;
   logic [7:0]  mask_reg = '0;
   logic [8:0]  pos_reg = '0;
   logic [7:0]  plain_hist [HIST_DEPTH];

   plaintext_feedback_xor_cipher_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic bit cipher_step(input cipher_req_type r, output cipher_rsp_type rsp);
      logic [7:0] result;
      logic [7:0] plain;
      logic [8:0] idx;
      rsp = '0;
      if (r.func == FUNC_KEY) begin
         if (r.first) begin
            key_acc = '0;
            key_slot = '0;
         end
         key_acc = key_acc + ({56'd0, r.data} << (8 * key_slot));
         key_slot = key_slot + 3'd1;
         return 1'b0;
      end
      if (r.func != FUNC_ENC && r.func != FUNC_DEC) return 1'b0;
      if (r.first) begin
         pos_reg = '0;
         mask_reg = key_acc[7:0];
      end
      result = r.data ^ mask_reg;
      plain = (r.func == FUNC_ENC) ? r.data : result;
      if (pos_reg < HIST_DEPTH) plain_hist[pos_reg[7:0]] = plain;
      if (pos_reg != 0) begin
         idx = mask_reg % pos_reg;
         mask_reg = plain_hist[idx[7:0]];
      end
      if (pos_reg < HIST_DEPTH) pos_reg = pos_reg + 9'd1;
      if (r.last) begin
         key_acc = key_acc * {32'd0, KEY_MUL} + KEY_ADD;
         pos_reg = '0;
         mask_reg = key_acc[7:0];
      end
      rsp.out_byte = result;
      rsp.eop = r.last;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_request(input logic [1:0] func, input logic [7:0] data,
                                input logic first, input logic last);
      cipher_req_type r;
      r = '0;
      r.func = func;
      r.data = data;
      r.first = first;
      r.last = last;
      request_queue.push_back(r);
      if (func != FUNC_NONE) live_count++;
   endtask

   task automatic build_stimulus();
      int pick;
      int pkt_len;
      int n;
      bit long_done;
      bit open;
      bit tail;
      logic [1:0] func;
      long_done = 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) request_queue.push_back(DIRECTED_PLAN[i]);
      live_count = 0;
      while (live_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (!long_done && live_count >= 150) begin
            pkt_len = $urandom_range(257, 300);
            pick = 10;
            long_done = 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            pkt_len = $urandom_range(13, 48);
         end else begin
            pkt_len = $urandom_range(1, 12);
         end
         if (pick < 4) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               queue_request(FUNC_KEY, pick_byte(),
                             (i == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 15) == 0),
                             1'($urandom_range(0, 1)));
         end else if (pick < 18) begin
            func = $urandom_range(0, 1) ? FUNC_ENC : FUNC_DEC;
            open = $urandom_range(0, 5) != 0;
            tail = $urandom_range(0, 7) != 0;
            for (int i = 0; i < pkt_len; i++) begin
               if ($urandom_range(0, 24) == 0)
                  queue_request($urandom_range(0, 1) ? FUNC_KEY : FUNC_NONE, pick_byte(),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               queue_request(func, pick_byte(),
                             (i == 0) ? open :
                                ((pkt_len <= 48) && ($urandom_range(0, 39) == 0)),
                             (i == pkt_len - 1) && tail);
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               queue_request(2'($urandom_range(0, 3)), pick_byte(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      planned_count = request_queue.size();
   endtask

   always @(posedge clock) begin
      cipher_rsp_type predicted;
      cipher_rsp_type oldest;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            accepted_count++;
            if (cipher_step(driven_req, predicted)) begin
               if (driven_req.has_exp) begin
                  predicted.out_byte = driven_req.exp_byte;
                  predicted.eop = driven_req.exp_eop;
               end
               expected_bytes.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: no result expected, actual %h", rsp_tdata);
               fail_count++;
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_tdata !== oldest.out_byte) begin
                  $error("out_byte: expected %h, actual %h", oldest.out_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== oldest.eop) begin
                  $error("end_of_packet: expected %b, actual %b", oldest.eop, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      logic           nxt_valid;
      logic           nxt_ready;
      cipher_req_type nxt;
      nxt_valid = req_tvalid;
      nxt = driven_req;
      nxt_ready = 1'b0;
      if (!reset && (!req_tvalid || req_taken)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_queue.size() > 0) begin
            nxt = request_queue.pop_front();
            nxt_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      if (!reset) begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
         end else begin
            rx_left--;
         end
         rx_phase++;
         case (rx_mode)
            RX_OPEN:   nxt_ready = 1'b1;
            RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: nxt_ready = ($urandom_range(0, 7) == 0);
            default:   nxt_ready = rx_phase[2];
         endcase
      end
      driven_req = nxt;
      req_tvalid <= nxt_valid;
      req_tdata <= nxt.data;
      req_tuser <= {nxt.first, nxt.func};
      req_tlast <= nxt.last;
      rsp_tready <= nxt_ready;
   end

   initial begin
      foreach (plain_hist[i]) plain_hist[i] = 8'd0;
      build_stimulus();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (accepted_count < planned_count || expected_bytes.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### plaintext_feedback_xor_cipher_top.f
rtl/pfxc_pkg.sv
rtl/pfxc_ram.sv
rtl/pfxc_ctrl.sv
rtl/pfxc_dpath.sv
rtl/plaintext_feedback_xor_cipher_top.sv
tb/sv/plaintext_feedback_xor_cipher_top_tb.sv
